/* rtl/class_limited_fifo_macros.svh */
// Assertion macros for the class-limited order queue.
// Used by the RTL files that check their own logic; no other dependencies.
`ifndef CLASS_LIMITED_FIFO_MACROS_SVH
`define CLASS_LIMITED_FIFO_MACROS_SVH

`ifndef SYNTHESIS
// Check that a condition holds at every edge out of reset
`define CLF_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);
// Check an implication within the same edge
`define CLF_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);
// Check an implication at the following edge
`define CLF_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);
`else
`define CLF_ASSERT(lbl, prop, msg)
`define CLF_ASSERT_IMP(lbl, ante, cons, msg)
`define CLF_ASSERT_NEXT(lbl, ante, cons, msg)
`endif

`endif

/* rtl/clf_pkg.sv */
// Shared types and constants for the class-limited order queue.
// No dependencies; used by class_limited_fifo.
package clf_pkg;

  // Default sizing
  localparam int DepthDefault        = 32;
  localparam int PayloadWidthDefault = 32;

  // Counter and configuration widths
  localparam int CountW   = 6;
  localparam int CfgIndexW = 1;

  // Configuration reset values
  localparam logic [CountW-1:0] CapacityReset  = 6'd25;
  localparam logic [CountW-1:0] SwapLimitReset = 6'd10;

  // Configuration register indexes
  typedef enum logic [CfgIndexW-1:0] {
    REG_CAPACITY   = 1'b0,
    REG_SWAP_LIMIT = 1'b1
  } cfg_reg_e;

  // Requested operation
  typedef enum logic {
    KIND_INSERT = 1'b0,
    KIND_REMOVE = 1'b1
  } kind_e;

  // Result status
  typedef enum logic [1:0] {
    ST_DONE       = 2'd0,
    ST_FULL       = 2'd1,
    ST_SWAP_LIMIT = 2'd2,
    ST_EMPTY      = 2'd3
  } status_e;

endpackage

/* rtl/class_limited_fifo.sv */
// Class-limited order queue: FIFO with capacity and swap-class limit.
// Depends on clf_pkg and class_limited_fifo_macros.svh.
//
//  channel | direction | handshake            | beat
//  --------+-----------+----------------------+------------------------------------
//  in      | input     | in_valid_i/in_stall_o   | kind, in_is_swap, in_payload
//  out     | output    | out_valid_o/out_stall_i | status, out_is_swap, out_payload,
//          |           |                         | occupancy, swap_count, spot_count
//  cfg     | input     | cfg_we_i (no wait)      | cfg_index_i, cfg_wdata_i
//
// One beat per cycle is accepted while the input does not stall; a result passes
// the pending stage (synchronous entry memory read) and then the output register.
// Pointers and counts update at accept; a removed entry's swap class is folded
// into the swap count the cycle after, when the memory read data arrives.
// Reset clears pointers, counts and valids; the entry memory needs no clearing.
// The input stalls only when the pending stage cannot move into a held output.
`include "class_limited_fifo_macros.svh"

module class_limited_fifo #(
  parameter int DEPTH         = clf_pkg::DepthDefault,
  parameter int PAYLOAD_WIDTH = clf_pkg::PayloadWidthDefault
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  // configuration
  input  logic                         cfg_we_i,
  input  logic [clf_pkg::CfgIndexW-1:0] cfg_index_i,
  input  logic [clf_pkg::CountW-1:0]   cfg_wdata_i,
  // input channel
  input  logic                         in_valid_i,
  output logic                         in_stall_o,
  input  logic                         kind_i,
  input  logic                         in_is_swap_i,
  input  logic [PAYLOAD_WIDTH-1:0]     in_payload_i,
  // output channel
  output logic                         out_valid_o,
  input  logic                         out_stall_i,
  output logic [1:0]                   status_o,
  output logic                         out_is_swap_o,
  output logic [PAYLOAD_WIDTH-1:0]     out_payload_o,
  output logic [clf_pkg::CountW-1:0]   occupancy_o,
  output logic [clf_pkg::CountW-1:0]   swap_count_o,
  output logic [clf_pkg::CountW-1:0]   spot_count_o
);

  localparam int AddrW = $clog2(DEPTH);
  localparam int CntW  = clf_pkg::CountW;
  localparam logic [AddrW-1:0] LastSlot = AddrW'(DEPTH - 1);
  // Largest usable capacity: DEPTH, or the counter range if that is smaller
  localparam logic [CntW-1:0] CapMax = (DEPTH < (1 << CntW)) ? CntW'(DEPTH) : '1;

  // Configuration registers
  logic [CntW-1:0] capacity_q, swap_limit_q;

  // Queue control state
  logic [AddrW-1:0] head_q, head_d, tail_q, tail_d;
  logic [CntW-1:0]  count_q, count_d, swaps_q, swaps_d, swaps_cur;

  // Entry memory: {is_swap, payload}
  logic [PAYLOAD_WIDTH:0] mem_q [DEPTH];
  logic [PAYLOAD_WIDTH:0] rd_q;
  logic                   fix_q;

  // Pending stage (waiting on memory read data)
  logic                  p_valid_q;
  clf_pkg::status_e      p_status_q, p_status_d;
  logic                  p_rem_q;
  logic [CntW-1:0]       p_count_q, p_swaps_q;
  logic                  p_move;

  // Output register
  logic                  out_valid_q;
  clf_pkg::status_e      out_status_q;
  logic                  out_is_swap_q;
  logic [PAYLOAD_WIDTH-1:0] out_payload_q;
  logic [CntW-1:0]       out_count_q, out_swaps_q, out_spots_q;

  logic            in_fire, ins_ok, rem_ok, full, swap_full;
  logic [CntW-1:0] cap_eff;
  logic            rd_swap;
  logic [CntW-1:0] p_swaps_fin;

  // Configuration writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      capacity_q   <= clf_pkg::CapacityReset;
      swap_limit_q <= clf_pkg::SwapLimitReset;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        clf_pkg::REG_CAPACITY:   capacity_q   <= cfg_wdata_i;
        clf_pkg::REG_SWAP_LIMIT: swap_limit_q <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  // Handshake: pending stage drains when the output slot is free or draining
  assign p_move     = p_valid_q && (!out_valid_q || !out_stall_i);
  assign in_stall_o = p_valid_q && !p_move;
  assign in_fire    = in_valid_i && !in_stall_o;

  // Fold a pending removed swap into the swap count
  assign rd_swap   = rd_q[PAYLOAD_WIDTH];
  assign swaps_cur = swaps_q - CntW'(fix_q && rd_swap);

  // Admission checks and next pointer/count values
  always_comb begin
    cap_eff    = (capacity_q > CapMax) ? CapMax : capacity_q;
    full       = count_q >= cap_eff;
    swap_full  = swaps_cur >= swap_limit_q;
    ins_ok     = 1'b0;
    rem_ok     = 1'b0;
    p_status_d = clf_pkg::ST_DONE;
    head_d     = head_q;
    tail_d     = tail_q;
    count_d    = count_q;
    swaps_d    = swaps_cur;
    if (in_fire) begin
      if (kind_i == clf_pkg::KIND_INSERT) begin
        if (full) begin
          p_status_d = clf_pkg::ST_FULL;
        end else if (in_is_swap_i && swap_full) begin
          p_status_d = clf_pkg::ST_SWAP_LIMIT;
        end else begin
          ins_ok  = 1'b1;
          tail_d  = (tail_q == LastSlot) ? '0 : tail_q + 1'b1;
          count_d = count_q + 1'b1;
          swaps_d = swaps_cur + CntW'(in_is_swap_i);
        end
      end else begin
        if (count_q == '0) begin
          p_status_d = clf_pkg::ST_EMPTY;
        end else begin
          rem_ok  = 1'b1;
          head_d  = (head_q == LastSlot) ? '0 : head_q + 1'b1;
          count_d = count_q - 1'b1;
        end
      end
    end
  end

  // Advance pointers and counts
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      head_q  <= '0;
      tail_q  <= '0;
      count_q <= '0;
      swaps_q <= '0;
      fix_q   <= 1'b0;
    end else begin
      head_q  <= head_d;
      tail_q  <= tail_d;
      count_q <= count_d;
      swaps_q <= swaps_d;
      fix_q   <= rem_ok;
    end
  end

  // Entry memory: write on insert, registered read on remove
  always_ff @(posedge clk_i) begin
    if (ins_ok) begin
      mem_q[tail_q] <= {in_is_swap_i, in_payload_i};
    end
    if (rem_ok) begin
      rd_q <= mem_q[head_q];
    end
  end

  // Pending stage
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      p_valid_q <= 1'b0;
    end else if (in_fire) begin
      p_valid_q <= 1'b1;
    end else if (p_move) begin
      p_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      p_status_q <= p_status_d;
      p_rem_q    <= rem_ok;
      p_count_q  <= count_d;
      p_swaps_q  <= swaps_d;
    end
  end

  // Swap count after a remove takes the entry's class into account
  assign p_swaps_fin = p_swaps_q - CntW'(p_rem_q && rd_swap);

  // Output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (p_move) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (p_move) begin
      out_status_q  <= p_status_q;
      out_is_swap_q <= p_rem_q && rd_swap;
      out_payload_q <= p_rem_q ? rd_q[PAYLOAD_WIDTH-1:0] : '0;
      out_count_q   <= p_count_q;
      out_swaps_q   <= p_swaps_fin;
      out_spots_q   <= p_count_q - p_swaps_fin;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign status_o      = out_status_q;
  assign out_is_swap_o = out_is_swap_q;
  assign out_payload_o = out_payload_q;
  assign occupancy_o   = out_count_q;
  assign swap_count_o  = out_swaps_q;
  assign spot_count_o  = out_spots_q;

  // Checks
  `CLF_ASSERT(a_swaps_le_count, swaps_cur <= count_q, "swap count exceeds occupancy")
  `CLF_ASSERT_NEXT(a_insert_counts, ins_ok, count_q == $past(count_q) + 1'b1, "insert count")
  `CLF_ASSERT_IMP(a_refused_zero, out_valid_q && out_status_q != clf_pkg::ST_DONE, out_payload_q == '0 && !out_is_swap_q, "refused result carries entry data")
  `CLF_ASSERT_NEXT(a_fix_once, fix_q, !fix_q || $past(rem_ok), "swap fold applied twice")

endmodule

/* verif/class_limited_fifo_tb.sv */
`timescale 1ns / 1ps
// Testbench for class_limited_fifo: directed and random order traffic under
// random bursts and receiver stalls, checked against an internal queue model.
// Depends on clf_pkg and the class_limited_fifo RTL.
module class_limited_fifo_tb;

  localparam int Depth    = clf_pkg::DepthDefault;
  localparam int PayloadW = clf_pkg::PayloadWidthDefault;

  // Predicted response for one accepted operation
  typedef struct packed {
    clf_pkg::status_e               status;
    logic                           swap;
    logic [PayloadW-1:0]            payload;
    logic [clf_pkg::CountW-1:0]     held;
    logic [clf_pkg::CountW-1:0]     swaps;
    logic [clf_pkg::CountW-1:0]     spots;
  } order_outcome_t;

  logic                          clk       = 1'b0;
  logic                          rst_n     = 1'b0;
  logic                          cfg_we    = 1'b0;
  logic [clf_pkg::CfgIndexW-1:0] cfg_index = '0;
  logic [clf_pkg::CountW-1:0]    cfg_wdata = '0;
  logic                          in_valid  = 1'b0;
  logic                          in_stall;
  logic                          kind      = 1'b0;
  logic                          in_swap   = 1'b0;
  logic [PayloadW-1:0]           in_payload = '0;
  logic                          out_valid;
  logic                          out_stall = 1'b0;
  logic [1:0]                    status;
  logic                          out_swap;
  logic [PayloadW-1:0]           out_payload;
  logic [clf_pkg::CountW-1:0]    occupancy;
  logic [clf_pkg::CountW-1:0]    swap_count;
  logic [clf_pkg::CountW-1:0]    spot_count;

  // Shadow of the queue contents, pointers, counts and settings
  logic [PayloadW-1:0]  slot_payload [Depth];
  logic                 slot_swap    [Depth];
  int unsigned          q_head       = 0;
  int unsigned          q_tail       = 0;
  int unsigned          q_held       = 0;
  int unsigned          q_swaps      = 0;
  int unsigned          q_capacity   = 32'(clf_pkg::CapacityReset);
  int unsigned          q_swap_limit = 32'(clf_pkg::SwapLimitReset);

  order_outcome_t       order_outcomes [$];
  int unsigned          mismatches = 0;

  // Receiver stall pattern state
  int unsigned          stall_span = 0;
  int unsigned          stall_pct  = 0;

  class_limited_fifo uut (
    .clk_i         (clk),
    .rst_ni        (rst_n),
    .cfg_we_i      (cfg_we),
    .cfg_index_i   (cfg_index),
    .cfg_wdata_i   (cfg_wdata),
    .in_valid_i    (in_valid),
    .in_stall_o    (in_stall),
    .kind_i        (kind),
    .in_is_swap_i  (in_swap),
    .in_payload_i  (in_payload),
    .out_valid_o   (out_valid),
    .out_stall_i   (out_stall),
    .status_o      (status),
    .out_is_swap_o (out_swap),
    .out_payload_o (out_payload),
    .occupancy_o   (occupancy),
    .swap_count_o  (swap_count),
    .spot_count_o  (spot_count)
  );

  always #6 clk = ~clk;

  // Apply one operation to the shadow queue and return its response
  function automatic order_outcome_t apply_order_op(clf_pkg::kind_e op, logic swap,
                                                    logic [PayloadW-1:0] data);
    order_outcome_t res;
    int unsigned    usable;
    res        = '0;
    res.status = clf_pkg::ST_DONE;
    usable     = (q_capacity > Depth) ? Depth : q_capacity;
    if (op == clf_pkg::KIND_INSERT) begin
      if (q_held >= usable) begin
        res.status = clf_pkg::ST_FULL;
      end else if (swap && q_swaps >= q_swap_limit) begin
        res.status = clf_pkg::ST_SWAP_LIMIT;
      end else begin
        slot_payload[q_tail] = data;
        slot_swap[q_tail]    = swap;
        q_tail = (q_tail + 1) % Depth;
        q_held++;
        if (swap) q_swaps++;
      end
    end else if (q_held == 0) begin
      res.status = clf_pkg::ST_EMPTY;
    end else begin
      // Class bit on a remove plays no part
      res.payload = slot_payload[q_head];
      res.swap    = slot_swap[q_head];
      q_head = (q_head + 1) % Depth;
      q_held--;
      if (res.swap && q_swaps > 0) q_swaps--;
    end
    res.held  = clf_pkg::CountW'(q_held);
    res.swaps = clf_pkg::CountW'(q_swaps);
    res.spots = clf_pkg::CountW'(q_held - q_swaps);
    return res;
  endfunction

  function automatic void compare_field(string name, logic [PayloadW-1:0] want,
                                        logic [PayloadW-1:0] got);
    if (want !== got) begin
      $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
      mismatches++;
    end
  endfunction

  // Check each result beat against the oldest predicted outcome
  always @(posedge clk) begin : check_results
    order_outcome_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (order_outcomes.size() == 0) begin
        $error("result beat arrived with no outcome pending");
        mismatches++;
      end else begin
        want = order_outcomes.pop_front();
        compare_field("status", PayloadW'(want.status), PayloadW'(status));
        compare_field("out_is_swap", PayloadW'(want.swap), PayloadW'(out_swap));
        compare_field("out_payload", want.payload, out_payload);
        compare_field("occupancy", PayloadW'(want.held), PayloadW'(occupancy));
        compare_field("swap_count", PayloadW'(want.swaps), PayloadW'(swap_count));
        compare_field("spot_count", PayloadW'(want.spots), PayloadW'(spot_count));
      end
    end
  end

  // Receiver: switch between stall densities, each held for a random span
  always @(posedge clk) begin
    if (stall_span == 0) begin
      stall_span <= $urandom_range(20, 200);
      case ($urandom_range(0, 3))
        0: stall_pct <= 0;
        1: stall_pct <= 25;
        2: stall_pct <= 60;
        default: stall_pct <= 95;
      endcase
    end else begin
      stall_span <= stall_span - 1;
    end
    out_stall <= ($urandom_range(0, 99) < stall_pct);
  end

  // Present one beat, hold it until accepted, then record its outcome
  task automatic send_order(clf_pkg::kind_e op, logic swap, logic [PayloadW-1:0] data);
    in_valid   <= 1'b1;
    kind       <= op;
    in_swap    <= swap;
    in_payload <= data;
    do @(posedge clk); while (in_stall);
    order_outcomes.push_back(apply_order_op(op, swap, data));
  endtask

  task automatic pause_sender(int unsigned cycles);
    if (cycles > 0) begin
      in_valid <= 1'b0;
      repeat (cycles) @(posedge clk);
    end
  endtask

  // Drop valid, wait for every outcome, then let the pipeline settle
  task automatic settle_queue();
    in_valid <= 1'b0;
    while (order_outcomes.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_setting(clf_pkg::cfg_reg_e idx, logic [clf_pkg::CountW-1:0] value);
    settle_queue();
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= value;
    @(posedge clk);
    cfg_we <= 1'b0;
    if (idx == clf_pkg::REG_CAPACITY) q_capacity = 32'(value);
    else q_swap_limit = 32'(value);
  endtask

  // Reset settings: empty removes, payload extremes, class bit on remove
  task automatic test_empty_and_defaults();
    send_order(clf_pkg::KIND_REMOVE, 1'b0, '0);
    send_order(clf_pkg::KIND_INSERT, 1'b0, '0);
    send_order(clf_pkg::KIND_INSERT, 1'b1, '1);
    send_order(clf_pkg::KIND_REMOVE, 1'b1, '1);
    send_order(clf_pkg::KIND_REMOVE, 1'b0, 32'h5A5A_A5A5);
    send_order(clf_pkg::KIND_REMOVE, 1'b1, '0);
  endtask

  // Swap limit refusal, and full takes priority over the swap limit
  task automatic test_full_before_limit();
    write_setting(clf_pkg::REG_CAPACITY, 6'd2);
    write_setting(clf_pkg::REG_SWAP_LIMIT, 6'd1);
    send_order(clf_pkg::KIND_INSERT, 1'b1, 32'hDEAD_0001);
    send_order(clf_pkg::KIND_INSERT, 1'b1, 32'hDEAD_0002);
    send_order(clf_pkg::KIND_INSERT, 1'b0, 32'hDEAD_0003);
    send_order(clf_pkg::KIND_INSERT, 1'b1, 32'hDEAD_0004);
    send_order(clf_pkg::KIND_INSERT, 1'b0, 32'hDEAD_0005);
    send_order(clf_pkg::KIND_REMOVE, 1'b0, '0);
    send_order(clf_pkg::KIND_REMOVE, 1'b0, '0);
  endtask

  // Zero capacity refuses every insert; zero swap limit refuses every swap
  task automatic test_degenerate_settings();
    write_setting(clf_pkg::REG_CAPACITY, 6'd0);
    write_setting(clf_pkg::REG_SWAP_LIMIT, 6'd63);
    send_order(clf_pkg::KIND_INSERT, 1'b0, 32'h0000_FFFF);
    send_order(clf_pkg::KIND_INSERT, 1'b1, 32'hFFFF_0000);
    write_setting(clf_pkg::REG_CAPACITY, 6'd63);
    write_setting(clf_pkg::REG_SWAP_LIMIT, 6'd0);
    send_order(clf_pkg::KIND_INSERT, 1'b1, 32'h1234_5678);
    send_order(clf_pkg::KIND_INSERT, 1'b0, 32'h8765_4321);
    send_order(clf_pkg::KIND_REMOVE, 1'b0, '0);
    send_order(clf_pkg::KIND_REMOVE, 1'b0, '0);
  endtask

  // Phases of random traffic, each under its own capacity and swap limit
  task automatic test_random_traffic();
    logic [clf_pkg::CountW-1:0] cap_plan [7] = '{6'd32, 6'd63, 6'd1, 6'd0, 6'd33, 6'd4, 6'd25};
    logic [clf_pkg::CountW-1:0] lim_plan [7] = '{6'd32, 6'd63, 6'd0, 6'd7, 6'd0, 6'd40, 6'd10};
    int unsigned         burst_left;
    int unsigned         run_left;
    int unsigned         insert_pct;
    int unsigned         swap_pct;
    clf_pkg::kind_e      op;
    logic                swap;
    logic [PayloadW-1:0] data;
    burst_left = 0;
    run_left   = 0;
    insert_pct = 50;
    for (int phase = 0; phase < 13; phase++) begin
      if (phase < 7) begin
        write_setting(clf_pkg::REG_CAPACITY, cap_plan[phase]);
        write_setting(clf_pkg::REG_SWAP_LIMIT, lim_plan[phase]);
      end else begin
        write_setting(clf_pkg::REG_CAPACITY, clf_pkg::CountW'($urandom_range(0, 63)));
        write_setting(clf_pkg::REG_SWAP_LIMIT, clf_pkg::CountW'($urandom_range(0, 63)));
      end
      swap_pct = $urandom_range(0, 100);
      for (int n = 0; n < 100; n++) begin
        // Alternate fill-heavy, drain-heavy and balanced runs
        if (run_left == 0) begin
          run_left = $urandom_range(8, 40);
          case ($urandom_range(0, 2))
            0: insert_pct = 85;
            1: insert_pct = 15;
            default: insert_pct = 50;
          endcase
        end
        run_left--;
        // Bursts of back-to-back beats separated by random gaps
        if (burst_left == 0) begin
          pause_sender(($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8));
          burst_left = $urandom_range(1, 30);
        end
        burst_left--;
        op   = ($urandom_range(0, 99) < insert_pct) ? clf_pkg::KIND_INSERT
                                                    : clf_pkg::KIND_REMOVE;
        swap = ($urandom_range(0, 99) < swap_pct);
        case ($urandom_range(0, 9))
          0: data = '0;
          1: data = '1;
          default: data = $urandom;
        endcase
        send_order(op, swap, data);
      end
    end
  endtask

  initial begin
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_empty_and_defaults();
    test_full_before_limit();
    test_degenerate_settings();
    test_random_traffic();
    settle_queue();
    if (mismatches == 0) begin
      $display("[class_limited_fifo] OK");
    end else begin
      $display("[class_limited_fifo] ERROR");
    end
    $finish;
  end

  // Hard stop if the run hangs
  initial begin
    #5_000_000;
    $display("[class_limited_fifo] ERROR");
    $finish;
  end

endmodule
